// ===== hdl/sns_pkg.sv =====
package sns_pkg;

  // Field and register widths.
  localparam int VALUE_BITS     = 24;
  localparam int SPAN_BITS      = 23;
  localparam int PCT_BITS       = 7;
  localparam int MOVE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN         = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_PERCENT = 2'd1;

  // Register reset values.
  localparam logic [SPAN_BITS-1:0] SPAN_RESET    = 23'd25600;
  localparam logic [PCT_BITS-1:0]  PERCENT_RESET = 7'd20;
  localparam logic [PCT_BITS-1:0]  PERCENT_MAX   = 7'd100;

  // Movement codes reported with each result.
  localparam logic [MOVE_BITS-1:0] MOVE_HELD      = 3'd0;
  localparam logic [MOVE_BITS-1:0] MOVE_FIRST     = 3'd1;
  localparam logic [MOVE_BITS-1:0] MOVE_SNAPPED   = 3'd2;
  localparam logic [MOVE_BITS-1:0] MOVE_STEPPED   = 3'd3;
  localparam logic [MOVE_BITS-1:0] MOVE_SETTLED   = 3'd4;
  localparam logic [MOVE_BITS-1:0] MOVE_RESTARTED = 3'd5;

  // Input opcodes.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Divide by 100 as a multiply by ceil(2^32 / 100) followed by a 32-bit shift.
  // It is exact for dividends below 2^27; a step only happens when the
  // distance is at most span/10 (below 2^20), times a percent of at most 100.
  localparam int SCALE_SHIFT    = 32;
  localparam int SCALE_BITS     = 33;
  localparam int STEP_MAG_BITS  = 20;
  localparam logic [SCALE_BITS-1:0] RECIP_100 = 33'd42949673;

  // Scale factor for a step percent, clamped to one hundred.
  function automatic logic [SCALE_BITS-1:0] percent_scale(input logic [PCT_BITS-1:0] pct);
    logic [PCT_BITS-1:0]   pct_c;
    logic [SCALE_BITS-1:0] prod;
    pct_c = (pct > PERCENT_MAX) ? PERCENT_MAX : pct;
    prod  = SCALE_BITS'(pct_c) * RECIP_100;
    return prod;
  endfunction

  // Smoother state carried between items.
  typedef struct packed {
    logic                  started;
    logic [VALUE_BITS-1:0] value;
  } sns_state_t;

  // One request as held in the input stage.
  typedef struct packed {
    logic                  opcode;
    logic [VALUE_BITS-1:0] sample;
    logic                  sample_bad;
  } sns_item_t;

endpackage

// ===== hdl/sns_step.sv =====
module sns_step
  import sns_pkg::*;
(
  input  sns_item_t             item,
  input  sns_state_t            cur,
  input  logic [SPAN_BITS-1:0]  span,
  input  logic [SCALE_BITS-1:0] scale,
  output sns_state_t            nxt,
  output logic [MOVE_BITS-1:0]  how
);

  localparam int PROD_BITS = STEP_MAG_BITS + SCALE_BITS;
  localparam int FAR_BITS  = VALUE_BITS + 4;
  localparam int NEAR_BITS = STEP_MAG_BITS + 10;

  logic signed [VALUE_BITS:0]   delta;
  logic                         neg;
  logic [VALUE_BITS:0]          mag;
  logic [FAR_BITS-1:0]          mag_x10;
  logic                         far;
  logic [STEP_MAG_BITS-1:0]     mag_s;
  logic [PROD_BITS-1:0]         prod;
  logic [STEP_MAG_BITS-1:0]     q;
  logic [STEP_MAG_BITS-1:0]     rest;
  logic [NEAR_BITS-1:0]         rest_x1000;
  logic                         near;
  logic [VALUE_BITS-1:0]        q_ext;
  logic [VALUE_BITS-1:0]        stepped;

  // Distance to the target and its magnitude.
  assign delta = $signed({item.sample[VALUE_BITS-1], item.sample})
               - $signed({cur.value[VALUE_BITS-1], cur.value});
  assign neg   = delta[VALUE_BITS];
  assign mag   = neg ? (VALUE_BITS + 1)'(0) - delta : delta;

  // Large jump: ten times the distance exceeds the span.
  assign mag_x10 = {mag, 3'b000} + {2'b00, mag, 1'b0};
  assign far     = mag_x10 > FAR_BITS'(span);

  // Step magnitude, truncated toward zero.
  assign mag_s = mag[STEP_MAG_BITS-1:0];
  assign prod  = PROD_BITS'(mag_s) * PROD_BITS'(scale);
  assign q     = prod[SCALE_SHIFT +: STEP_MAG_BITS];

  // The step never overshoots, so the remaining distance is the old one minus the step.
  assign rest       = mag_s - q;
  assign rest_x1000 = NEAR_BITS'(rest) * NEAR_BITS'(1000);
  assign near       = rest_x1000 < NEAR_BITS'(span);

  assign q_ext   = VALUE_BITS'(q);
  assign stepped = neg ? cur.value - q_ext : cur.value + q_ext;

  // Select the outcome for this request.
  always_comb begin
    nxt = cur;
    how = MOVE_HELD;
    if (item.opcode == OP_RESTART) begin
      nxt.started = 1'b0;
      nxt.value   = '0;
      how         = MOVE_RESTARTED;
    end else if (item.sample_bad) begin
      how = MOVE_HELD;
    end else if (!cur.started) begin
      nxt.started = 1'b1;
      nxt.value   = item.sample;
      how         = MOVE_FIRST;
    end else if (far) begin
      nxt.value = item.sample;
      how       = MOVE_SNAPPED;
    end else if (near) begin
      nxt.value = item.sample;
      how       = MOVE_SETTLED;
    end else begin
      nxt.value = stepped;
      how       = MOVE_STEPPED;
    end
  end

endmodule

// ===== hdl/snap_and_settle_smoother.sv =====
// Pipeline: one input register and one result register, nothing else; a request
// accepted into the input register moves on when the result register frees up.
// Throughput: one request per cycle while out_stall is low; the smoother state is
// updated in the same cycle a result is loaded, so the next request sees it
// without a bubble. Reset (rst_n low, synchronous) clears both pipeline stages and
// the state and loads span 25600 and step percent 20.
module snap_and_settle_smoother
  import sns_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [VALUE_BITS-1:0] in_sample,
  input  logic                      in_sample_bad,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_BITS-1:0] out_shown_value,
  output logic [MOVE_BITS-1:0]      out_how_moved,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SPAN_BITS-1:0]      cfg_data
);

  logic                  s1_valid_r;
  sns_item_t             s1_item_r;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [MOVE_BITS-1:0]  out_how_r;
  sns_state_t            state_r;
  logic [SPAN_BITS-1:0]  span_r;
  logic [SCALE_BITS-1:0] scale_r;

  sns_state_t            state_nxt;
  logic [MOVE_BITS-1:0]  how_nxt;
  logic                  advance;
  logic                  s1_load;

  // The result register frees up when empty or when its request is taken.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign s1_load  = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_shown_value = $signed(out_value_r);
  assign out_how_moved   = out_how_r;
  assign cfg_ready       = 1'b1;

  // Configuration registers; the step percent is kept as its divide scale.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r  <= SPAN_RESET;
      scale_r <= percent_scale(PERCENT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPAN:         span_r  <= cfg_data;
        REG_STEP_PERCENT: scale_r <= percent_scale(cfg_data[PCT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r.opcode     <= in_opcode;
      s1_item_r.sample     <= in_sample;
      s1_item_r.sample_bad <= in_sample_bad;
    end
  end

  // Smoothing step between the two registers.
  sns_step u_step (
    .item  (s1_item_r),
    .cur   (state_r),
    .span  (span_r),
    .scale (scale_r),
    .nxt   (state_nxt),
    .how   (how_nxt)
  );

  // State and result register update together as a request leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_value_r <= state_nxt.value;
      out_how_r   <= how_nxt;
    end
  end

endmodule
